FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is applied.
`define BVRE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bit vector engine check failed");

// Clocked check that also holds during reset.
`define BVRE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bit vector engine reset check failed");

`endif

FILE: design/bvre_pkg.sv
// Package: types, codes and constants of the bit vector range engine.
`default_nettype none
package bvre_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned TALLY_W = 13;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned ST_W    = 2;

  localparam int unsigned MAP_BITS_DEF  = 4096;
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_RANGE = 3'd2,
    REQ_COUNT = 3'd3,
    REQ_FIND  = 3'd4
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_COUNT,
    OP_FIND
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic run;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic chk_err;
    logic chk_skip;
    logic walk_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/bvre_req_if.sv
// Interface: request channel.
`default_nettype none
interface bvre_req_if;
  import bvre_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [POS_W-1:0]   position;
  logic [LEN_W-1:0]   run_length;
  logic [POS_W-1:0]   end_position;
  logic               bit_value;
  modport source (output valid, req_type, position, run_length, end_position, bit_value,
                  input ready);
  modport sink   (input valid, req_type, position, run_length, end_position, bit_value,
                  output ready);
endinterface
`default_nettype wire

FILE: design/bvre_rsp_if.sv
// Interface: result channel.
`default_nettype none
interface bvre_rsp_if;
  import bvre_pkg::*;
  logic               valid;
  logic               ready;
  logic               read_bit;
  logic [TALLY_W-1:0] ones_tally;
  logic [POS_W-1:0]   found_index;
  logic [ST_W-1:0]    status;
  modport source (output valid, read_bit, ones_tally, found_index, status, input ready);
  modport sink   (input valid, read_bit, ones_tally, found_index, status, output ready);
endinterface
`default_nettype wire

FILE: design/bvre_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none
interface bvre_cfg_if;
  import bvre_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: design/bvre_ctrl.sv
// Controller: request sequencing state machine and result valid.
`default_nettype none
module bvre_ctrl
  import bvre_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = (sts_i.chk_err || sts_i.chk_skip) ? S_FIN : S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_WALK: begin
        cmd_o.run = 1'b1;
      end
      S_FIN: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: design/bvre_dp.sv
// Datapath: word memory, range walk, masking, tally, search and result register.
`default_nettype none
module bvre_dp
  import bvre_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [LEN_W-1:0]   run_length_i,
  input  wire logic [POS_W-1:0]   end_position_i,
  input  wire logic               bit_value_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [SIZE_W-1:0]  cfg_data_i,
  output logic                    read_bit_o,
  output logic [TALLY_W-1:0]      ones_tally_o,
  output logic [POS_W-1:0]        found_index_o,
  output logic [ST_W-1:0]         status_o
);

  localparam int unsigned WORD_COUNT = MAP_BITS / WORD_BITS;
  localparam int unsigned WB_W       = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [WB_W-1:0] TOP_BIT = WB_W'(WORD_BITS - 1);

  // Size register
  logic [SIZE_W-1:0] bits_q;
  logic [31:0]       size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bits_q <= SIZE_RESET;
    else if (cfg_valid_i) bits_q <= cfg_data_i;
  end

  assign size = (32'(bits_q) < 32'(MAP_BITS)) ? 32'(bits_q) : 32'(MAP_BITS);

  // Check the request and derive its span
  logic             chk_err, chk_skip;
  logic [POS_W-1:0] span_lo, span_hi;
  op_e              chk_op;
  logic [LEN_W-1:0] run_end;
  logic [31:0]      lo_wide, hi_wide;

  assign run_end = LEN_W'(position_i) + run_length_i - LEN_W'(1);

  always_comb begin
    chk_err  = 1'b0;
    chk_skip = 1'b0;
    span_lo  = position_i;
    span_hi  = position_i;
    chk_op   = OP_COUNT;
    case (req_type_i)
      REQ_READ: begin
        chk_err = 32'(position_i) >= size;
      end
      REQ_WRITE: begin
        chk_err = 32'(position_i) >= size;
        chk_op  = OP_WRITE;
      end
      REQ_RANGE: begin
        chk_skip = run_length_i == '0;
        chk_err  = !chk_skip && (32'(position_i) + 32'(run_length_i) > size);
        span_hi  = run_end[POS_W-1:0];
        chk_op   = OP_WRITE;
      end
      REQ_COUNT: begin
        chk_err = (position_i > end_position_i) || (32'(end_position_i) >= size);
        span_hi = end_position_i;
      end
      REQ_FIND: begin
        chk_err = (position_i > end_position_i) || (32'(end_position_i) >= size);
        span_hi = end_position_i;
        chk_op  = OP_FIND;
      end
      default: chk_err = 1'b1;
    endcase
  end

  assign lo_wide = 32'(span_lo) >> WB_W;
  assign hi_wide = 32'(span_hi) >> WB_W;

  // Request registers and walk state
  logic [2:0]        kind_q;
  logic              err_q, val_q;
  op_e               op_q;
  logic [WIDX_W-1:0] wlo_q, whi_q, p_idx_q;
  logic [WB_W-1:0]   blo_q, bhi_q;
  logic [WIDX_W:0]   rd_idx_q;
  logic              p_valid_q;
  logic [TALLY_W-1:0] tally_q;
  logic              hit_q;
  logic [POS_W-1:0]  found_q;

  logic              rd_en, proc_en, wr_en;
  logic [WORD_BITS-1:0] word, mask, match, wdata;
  logic [WB_W-1:0]   lo_b, hi_b, enc;
  logic [31:0]       found_wide;

  assign rd_en   = cmd_i.run && (rd_idx_q <= {1'b0, whi_q});
  assign proc_en = cmd_i.run && p_valid_q;

  // Memory with per-word valid bits; an unwritten word reads as zero
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] mem_rd_q;
  logic [WORD_COUNT-1:0] word_vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) mem_rd_q <= mem[rd_idx_q[WIDX_W-1:0]];
    if (wr_en) mem[p_idx_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (rd_en) rd_vld_q <= word_vld_q[rd_idx_q[WIDX_W-1:0]];
      if (wr_en) word_vld_q[p_idx_q] <= 1'b1;
    end
  end

  assign word = rd_vld_q ? mem_rd_q : '0;

  // Mask the word to the span
  assign lo_b  = (p_idx_q == wlo_q) ? blo_q : '0;
  assign hi_b  = (p_idx_q == whi_q) ? bhi_q : TOP_BIT;
  assign mask  = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (TOP_BIT - hi_b));
  assign match = (val_q ? word : ~word) & mask;
  assign wdata = val_q ? (word | mask) : (word & ~mask);
  assign wr_en = proc_en && (op_q == OP_WRITE);

  // Lowest matching bit
  always_comb begin
    enc = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (match[i]) enc = WB_W'(i);
    end
  end

  assign found_wide = (32'(p_idx_q) << WB_W) | 32'(enc);

  // Walk and accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      rd_idx_q  <= '0;
    end else if (cmd_i.load) begin
      p_valid_q <= 1'b0;
      rd_idx_q  <= {1'b0, lo_wide[WIDX_W-1:0]};
    end else begin
      p_valid_q <= rd_en;
      if (rd_en) rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_type_i;
      err_q   <= chk_err;
      op_q    <= chk_op;
      val_q   <= bit_value_i;
      wlo_q   <= lo_wide[WIDX_W-1:0];
      whi_q   <= hi_wide[WIDX_W-1:0];
      blo_q   <= span_lo[WB_W-1:0];
      bhi_q   <= span_hi[WB_W-1:0];
      tally_q <= '0;
      hit_q   <= 1'b0;
      found_q <= '0;
    end else if (proc_en) begin
      if (op_q == OP_COUNT) tally_q <= tally_q + TALLY_W'($countones(word & mask));
      if (op_q == OP_FIND && |match) begin
        hit_q   <= 1'b1;
        found_q <= found_wide[POS_W-1:0];
      end
    end
    if (rd_en) p_idx_q <= rd_idx_q[WIDX_W-1:0];
  end

  assign sts_o.chk_err   = chk_err;
  assign sts_o.chk_skip  = chk_skip;
  assign sts_o.walk_done = proc_en && ((p_idx_q == whi_q) || (op_q == OP_FIND && |match));

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_bit_o    <= !err_q && (kind_q == REQ_READ) && tally_q[0];
      ones_tally_o  <= (!err_q && kind_q == REQ_COUNT) ? tally_q : '0;
      found_index_o <= (!err_q && hit_q) ? found_q : '0;
      if (err_q) status_o <= ST_RANGE;
      else if (kind_q == REQ_FIND && !hit_q) status_o <= ST_NOTFOUND;
      else status_o <= ST_OK;
    end
  end

endmodule
`default_nettype wire

FILE: design/bit_vector_range_engine_top.sv
// Top level of the bit vector range engine.
//
//   channel  dir  handshake    payload
//   req_if   in   valid/ready  req_type, position, run_length, end_position, bit_value
//   rsp_if   out  valid/ready  read_bit, ones_tally, found_index, status
//   cfg_if   in   valid/ready  data (bits_in_use), always ready
//
// One request at a time. A rejected or zero-length request goes straight to its result.
// A walking request reads the words it spans through the single memory read port,
// streaming one word per cycle; a find stops at the first matching word.
// Reset clears the store at once through per-word valid bits; size resets to 4096.
// A result held by a stalled consumer keeps its register; the next request is still taken.
`default_nettype none
module bit_vector_range_engine_top
  import bvre_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bvre_req_if.sink   req_if,
  bvre_rsp_if.source rsp_if,
  bvre_cfg_if.sink   cfg_if
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_if.ready = 1'b1;

  bvre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .rsp_valid_o (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bvre_dp #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_if.req_type),
    .position_i     (req_if.position),
    .run_length_i   (req_if.run_length),
    .end_position_i (req_if.end_position),
    .bit_value_i    (req_if.bit_value),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_data_i     (cfg_if.data),
    .read_bit_o     (rsp_if.read_bit),
    .ones_tally_o   (rsp_if.ones_tally),
    .found_index_o  (rsp_if.found_index),
    .status_o       (rsp_if.status)
  );

endmodule
`default_nettype wire

FILE: design/bvre_checker.sv
// Checker on the top level ports, with its bind.
`default_nettype none
`include "assert_macros.svh"
module bvre_checker
  import bvre_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               read_bit,
  input wire logic [TALLY_W-1:0] ones_tally,
  input wire logic [POS_W-1:0]   found_index,
  input wire logic [ST_W-1:0]    status
);

  `BVRE_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ones_tally) && $stable(found_index))
  `BVRE_ASSERT(a_status_code, clk_i, rst_ni, rsp_valid |-> status != 2'd3)
  `BVRE_ASSERT(a_fail_clean, clk_i, rst_ni, rsp_valid && status != ST_OK |-> !read_bit && ones_tally == '0 && found_index == '0)
  `BVRE_ASSERT(a_no_instant_rsp, clk_i, rst_ni, req_valid && req_ready |=> !$rose(rsp_valid))
  `BVRE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !rsp_valid)

endmodule

bind bit_vector_range_engine_top bvre_checker u_bvre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req_if.valid),
  .req_ready   (req_if.ready),
  .rsp_valid   (rsp_if.valid),
  .rsp_ready   (rsp_if.ready),
  .read_bit    (rsp_if.read_bit),
  .ones_tally  (rsp_if.ones_tally),
  .found_index (rsp_if.found_index),
  .status      (rsp_if.status)
);
`default_nettype wire
